@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, sampled on a clock with an active-low
// asynchronous reset disabling the check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every sampled edge outside reset
`define TCW_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define TCW_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

@@ sv/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, word types and state encoding of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int ROWS      = 25;
	localparam int COLS      = 80;
	localparam int TAB_WIDTH = 4;

	localparam int CELL_COUNT = ROWS * COLS;
	localparam int CELL_W     = $clog2(CELL_COUNT);
	localparam int COL_W      = $clog2(COLS);
	localparam int LEFT_W     = $clog2(TAB_WIDTH + 1);
	localparam int DIV_DMAX   = (COLS > TAB_WIDTH) ? COLS : TAB_WIDTH;
	localparam int DIV_REM_W  = $clog2(DIV_DMAX);
	localparam int CFG_ADDR_W = 3;

	localparam int DIV_SHIFT      = 19;
	localparam int DIV_RECIP_COLS = (2 ** DIV_SHIFT + COLS - 1) / COLS;
	localparam int DIV_RECIP_TAB  = (2 ** DIV_SHIFT + TAB_WIDTH - 1) / TAB_WIDTH;
	localparam int DIV_RECIP_MAX  = (DIV_RECIP_COLS > DIV_RECIP_TAB) ? DIV_RECIP_COLS
	                                                                 : DIV_RECIP_TAB;
	localparam int DIV_RECIP_W    = $clog2(DIV_RECIP_MAX + 1);
	localparam int DIV_PROD_W     = CELL_W + DIV_RECIP_W;
	localparam int DIV_QUO_W      = DIV_PROD_W - DIV_SHIFT;

	localparam logic [CELL_W-1:0] CELL_LAST = CELL_W'(CELL_COUNT - 1);
	localparam logic [CELL_W-1:0] LAST_LINE = CELL_W'((ROWS - 1) * COLS);

	localparam logic [7:0] BLANK_CHAR   = 8'h20;
	localparam logic [7:0] RESET_ATTR   = 8'h07;
	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] CODE_TAB     = 8'd9;

	localparam logic [2:0] OP_TEXT   = 3'd0;
	localparam logic [2:0] OP_RAW    = 3'd1;
	localparam logic [2:0] OP_AT     = 3'd2;
	localparam logic [2:0] OP_CURSOR = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;

	localparam logic [CFG_ADDR_W-3:0] REG_DEFAULT_COLOR = '0;

	typedef struct packed {
		logic [2:0]  op;
		logic [7:0]  char_code;
		logic [7:0]  color;
		logic [4:0]  row;
		logic [6:0]  col;
		logic [10:0] cursor_target;
	} in_word_t;

	typedef struct packed {
		logic [10:0] cursor_pos;
		logic [7:0]  read_char;
		logic [7:0]  read_color;
		logic        scrolled;
	} out_word_t;

	typedef struct packed {
		logic              start;
		logic              by_cols;
		logic [CELL_W-1:0] dividend;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_REM_W-1:0] rem;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DIV,
		ST_PUT,
		ST_BLANK,
		ST_POS,
		ST_MEM,
		ST_RDWAIT,
		ST_DONE
	} ctrl_state_t;

endpackage

@@ sv/text_console_writer.sv @@
// Reset: the screen store is swept to blanks (space, attribute 0x07), one cell a cycle, after
//   reset release; no word is accepted until the sweep ends.
// Sequence: a character is put; a positioned write or read forms the address, then writes or
//   reads, a read then capturing the data; a newline or other word goes to the result; a tab or
//   cursor set waits for the remainder, a tab then puts each space; a scroll blanks a row.
// Throughput: one word in flight; the next is taken the cycle after the result register loads.
// ----------------------------------------------------------------------------
// text_console_writer
// 80x25 text console: screen store, cursor, scrolling and a configuration port.
// ----------------------------------------------------------------------------
module text_console_writer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tcw_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  tcw_pkg::in_word_t                 req,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output tcw_pkg::out_word_t                rsp
);

	logic [7:0]                  default_color_q;
	logic                        rsp_valid_q;
	tcw_pkg::out_word_t          rsp_q;
	logic                        res_valid;
	logic                        res_ready;
	tcw_pkg::out_word_t          res;
	tcw_pkg::div_req_t           div_req;
	tcw_pkg::div_rsp_t           div_rsp;
	logic                        mem_we;
	logic [tcw_pkg::CELL_W-1:0]  mem_addr;
	logic [15:0]                 mem_wdata;
	logic [15:0]                 mem_rdata;
	logic                        reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[tcw_pkg::CFG_ADDR_W-1:2] == tcw_pkg::REG_DEFAULT_COLOR);
	assign prdata  = reg_hit ? 32'(default_color_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_color_q <= tcw_pkg::RESET_ATTR;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			default_color_q <= pwdata[7:0];
		end
	end

	assign res_ready = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	tcw_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req           (req),
		.default_color (default_color_q),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res),
		.div_req       (div_req),
		.div_rsp       (div_rsp),
		.mem_we        (mem_we),
		.mem_addr      (mem_addr),
		.mem_wdata     (mem_wdata),
		.mem_rdata     (mem_rdata)
	);

	tcw_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	tcw_ram #(
		.WIDTH (16),
		.DEPTH (tcw_pkg::CELL_COUNT)
	) u_screen (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule

@@ sv/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// tcw_ram
// Single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ sv/tcw_div.sv @@
// ----------------------------------------------------------------------------
// tcw_div
// Remainder unit: reciprocal multiplication by the column count or the tab
// width, then multiply back and subtract; the dividend, quotient and remainder
// are registered in turn, and done rises with the remainder.
// ----------------------------------------------------------------------------
module tcw_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tcw_pkg::div_req_t  req,
	output tcw_pkg::div_rsp_t  rsp
);

	logic                              vld_s1;
	logic                              vld_s2;
	logic                              done_q;
	logic                              by_cols_q;
	logic [tcw_pkg::CELL_W-1:0]        dvd_q;
	logic [tcw_pkg::DIV_QUO_W-1:0]     quo_s2;
	logic [tcw_pkg::DIV_REM_W-1:0]     rem_q;
	logic [tcw_pkg::DIV_RECIP_W-1:0]   recip;
	logic [tcw_pkg::DIV_PROD_W-1:0]    prod;
	logic [tcw_pkg::CELL_W-1:0]        dsr;
	logic [tcw_pkg::CELL_W-1:0]        back;
	logic [tcw_pkg::CELL_W-1:0]        rem;

	assign recip = by_cols_q ? tcw_pkg::DIV_RECIP_W'(tcw_pkg::DIV_RECIP_COLS)
	                         : tcw_pkg::DIV_RECIP_W'(tcw_pkg::DIV_RECIP_TAB);
	assign dsr   = by_cols_q ? tcw_pkg::CELL_W'(tcw_pkg::COLS)
	                         : tcw_pkg::CELL_W'(tcw_pkg::TAB_WIDTH);
	assign prod  = tcw_pkg::DIV_PROD_W'(dvd_q) * tcw_pkg::DIV_PROD_W'(recip);
	assign back  = tcw_pkg::CELL_W'(quo_s2) * dsr;
	assign rem   = dvd_q - back;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= req.start;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q     <= req.dividend;
			by_cols_q <= req.by_cols;
		end
		if (vld_s1) begin
			quo_s2 <= prod[tcw_pkg::DIV_PROD_W-1:tcw_pkg::DIV_SHIFT];
		end
		if (vld_s2) begin
			rem_q <= rem[tcw_pkg::DIV_REM_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

@@ sv/tcw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the console: clears the screen store, writes and reads cells,
// advances the cursor and scrolls by rotating the row origin of the store.
// ----------------------------------------------------------------------------
module tcw_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	output logic                        req_stall,
	input  tcw_pkg::in_word_t           req,
	input  logic [7:0]                  default_color,
	output logic                        res_valid,
	input  logic                        res_ready,
	output tcw_pkg::out_word_t          res,
	output tcw_pkg::div_req_t           div_req,
	input  tcw_pkg::div_rsp_t           div_rsp,
	output logic                        mem_we,
	output logic [tcw_pkg::CELL_W-1:0]  mem_addr,
	output logic [15:0]                 mem_wdata,
	input  logic [15:0]                 mem_rdata
);

	tcw_pkg::ctrl_state_t state_q, state_d;

	logic [tcw_pkg::CELL_W-1:0] clr_q;
	logic [tcw_pkg::CELL_W-1:0] cursor_q;
	logic [tcw_pkg::COL_W-1:0]  col_q;
	logic [tcw_pkg::CELL_W-1:0] top_off_q;

	tcw_pkg::in_word_t          req_q;
	logic [tcw_pkg::CELL_W-1:0] lin_q;
	logic [tcw_pkg::LEFT_W-1:0] left_q;
	logic [tcw_pkg::COL_W-1:0]  cnt_q;
	logic [7:0]                 put_char_q;
	logic [7:0]                 put_attr_q;
	logic [7:0]                 rd_char_q;
	logic [7:0]                 rd_color_q;
	logic                       scrolled_q;

	logic accept;
	logic is_nl;
	logic is_tab;
	logic on_last;
	logic pos_ok;
	logic tgt_ok;
	logic row_wrap;
	logic blank_end;

	function automatic logic [tcw_pkg::CELL_W-1:0] phys(
		input logic [tcw_pkg::CELL_W-1:0] lin,
		input logic [tcw_pkg::CELL_W-1:0] off
	);
		logic [tcw_pkg::CELL_W:0] sum;
		sum = {1'b0, lin} + {1'b0, off};
		if (sum >= (tcw_pkg::CELL_W+1)'(tcw_pkg::CELL_COUNT)) begin
			sum = sum - (tcw_pkg::CELL_W+1)'(tcw_pkg::CELL_COUNT);
		end
		return sum[tcw_pkg::CELL_W-1:0];
	endfunction

	assign accept    = (state_q == tcw_pkg::ST_IDLE) && req_valid;
	assign is_nl     = (req.char_code == tcw_pkg::CODE_NEWLINE);
	assign is_tab    = (req.char_code == tcw_pkg::CODE_TAB);
	assign on_last   = (cursor_q >= tcw_pkg::LAST_LINE);
	assign pos_ok    = (int'(req.row) < tcw_pkg::ROWS) && (int'(req.col) < tcw_pkg::COLS);
	assign tgt_ok    = (int'(req.cursor_target) < tcw_pkg::CELL_COUNT);
	assign row_wrap  = (col_q == tcw_pkg::COL_W'(tcw_pkg::COLS - 1));
	assign blank_end = (cnt_q == tcw_pkg::COL_W'(tcw_pkg::COLS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		res_valid = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = '0;
		mem_wdata = '0;
		div_req   = '0;
		unique case (state_q)
			tcw_pkg::ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_q;
				mem_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR};
				if (clr_q == tcw_pkg::CELL_LAST) begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			tcw_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					unique case (req.op) inside
						tcw_pkg::OP_TEXT: begin
							if (is_nl) begin
								state_d = on_last ? tcw_pkg::ST_BLANK : tcw_pkg::ST_DONE;
							end else if (is_tab) begin
								div_req.start    = 1'b1;
								div_req.by_cols  = 1'b0;
								div_req.dividend = cursor_q;
								state_d          = tcw_pkg::ST_DIV;
							end else begin
								state_d = tcw_pkg::ST_PUT;
							end
						end
						tcw_pkg::OP_RAW: begin
							state_d = tcw_pkg::ST_PUT;
						end
						tcw_pkg::OP_AT, tcw_pkg::OP_READ: begin
							state_d = pos_ok ? tcw_pkg::ST_POS : tcw_pkg::ST_DONE;
						end
						tcw_pkg::OP_CURSOR: begin
							if (tgt_ok) begin
								div_req.start    = 1'b1;
								div_req.by_cols  = 1'b1;
								div_req.dividend = req.cursor_target;
								state_d          = tcw_pkg::ST_DIV;
							end else begin
								state_d = tcw_pkg::ST_DONE;
							end
						end
						default: begin
							state_d = tcw_pkg::ST_DONE;
						end
					endcase
				end
			end
			tcw_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					state_d = (req_q.op == tcw_pkg::OP_CURSOR) ? tcw_pkg::ST_DONE
					                                           : tcw_pkg::ST_PUT;
				end
			end
			tcw_pkg::ST_PUT: begin
				mem_we    = 1'b1;
				mem_addr  = phys(cursor_q, top_off_q);
				mem_wdata = {put_attr_q, put_char_q};
				if (cursor_q == tcw_pkg::CELL_LAST) begin
					state_d = tcw_pkg::ST_BLANK;
				end else if (left_q == tcw_pkg::LEFT_W'(1)) begin
					state_d = tcw_pkg::ST_DONE;
				end
			end
			tcw_pkg::ST_BLANK: begin
				mem_we    = 1'b1;
				mem_addr  = top_off_q + tcw_pkg::CELL_W'(cnt_q);
				mem_wdata = {default_color, tcw_pkg::BLANK_CHAR};
				if (blank_end) begin
					state_d = (left_q != '0) ? tcw_pkg::ST_PUT : tcw_pkg::ST_DONE;
				end
			end
			tcw_pkg::ST_POS: begin
				state_d = tcw_pkg::ST_MEM;
			end
			tcw_pkg::ST_MEM: begin
				mem_addr = phys(lin_q, top_off_q);
				if (req_q.op == tcw_pkg::OP_AT) begin
					mem_we    = 1'b1;
					mem_wdata = {req_q.color, req_q.char_code};
					state_d   = tcw_pkg::ST_DONE;
				end else begin
					state_d = tcw_pkg::ST_RDWAIT;
				end
			end
			tcw_pkg::ST_RDWAIT: begin
				state_d = tcw_pkg::ST_DONE;
			end
			tcw_pkg::ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = tcw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tcw_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			cursor_q  <= '0;
			col_q     <= '0;
			top_off_q <= '0;
		end else begin
			if (state_q == tcw_pkg::ST_CLEAR) begin
				clr_q <= clr_q + tcw_pkg::CELL_W'(1);
			end
			if (accept && req.op == tcw_pkg::OP_TEXT && is_nl && !on_last) begin
				cursor_q <= tcw_pkg::CELL_W'(int'(cursor_q) - int'(col_q) + tcw_pkg::COLS);
				col_q    <= '0;
			end
			if (state_q == tcw_pkg::ST_DIV && div_rsp.done && req_q.op == tcw_pkg::OP_CURSOR) begin
				cursor_q <= req_q.cursor_target;
				col_q    <= tcw_pkg::COL_W'(div_rsp.rem);
			end
			if (state_q == tcw_pkg::ST_PUT && cursor_q != tcw_pkg::CELL_LAST) begin
				cursor_q <= cursor_q + tcw_pkg::CELL_W'(1);
				col_q    <= row_wrap ? '0 : col_q + tcw_pkg::COL_W'(1);
			end
			if (state_q == tcw_pkg::ST_BLANK && blank_end) begin
				cursor_q  <= tcw_pkg::LAST_LINE;
				col_q     <= '0;
				top_off_q <= (top_off_q == tcw_pkg::LAST_LINE) ? '0
				           : top_off_q + tcw_pkg::CELL_W'(tcw_pkg::COLS);
			end
		end
	end

	always_ff @(posedge clk) begin
		cnt_q <= (state_q == tcw_pkg::ST_BLANK) ? cnt_q + tcw_pkg::COL_W'(1) : '0;
		if (accept) begin
			req_q      <= req;
			scrolled_q <= 1'b0;
			rd_char_q  <= '0;
			rd_color_q <= '0;
			left_q     <= (req.op == tcw_pkg::OP_TEXT && is_nl) ? '0 : tcw_pkg::LEFT_W'(1);
			if (req.op == tcw_pkg::OP_TEXT) begin
				put_char_q <= is_tab ? tcw_pkg::BLANK_CHAR : req.char_code;
				put_attr_q <= default_color;
			end else begin
				put_char_q <= req.char_code;
				put_attr_q <= req.color;
			end
		end
		if (state_q == tcw_pkg::ST_DIV && div_rsp.done) begin
			left_q <= tcw_pkg::LEFT_W'(tcw_pkg::TAB_WIDTH - int'(div_rsp.rem));
		end
		if (state_q == tcw_pkg::ST_PUT) begin
			left_q <= left_q - tcw_pkg::LEFT_W'(1);
		end
		if (state_q == tcw_pkg::ST_BLANK) begin
			scrolled_q <= 1'b1;
		end
		if (state_q == tcw_pkg::ST_POS) begin
			lin_q <= tcw_pkg::CELL_W'(int'(req_q.row) * tcw_pkg::COLS + int'(req_q.col));
		end
		if (state_q == tcw_pkg::ST_RDWAIT) begin
			rd_char_q  <= mem_rdata[7:0];
			rd_color_q <= mem_rdata[15:8];
		end
	end

	assign res.cursor_pos = cursor_q;
	assign res.read_char  = rd_char_q;
	assign res.read_color = rd_color_q;
	assign res.scrolled   = scrolled_q;

endmodule

@@ sv/tcw_checker.sv @@
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input tcw_pkg::out_word_t rsp
);

	`TCW_ASSERT(a_one_word, clk, arst_n, req_valid && !req_stall |=> req_stall, "word accepted while another in flight")
	`TCW_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled result changed")
	`TCW_ASSERT_NEVER(a_cursor_range, clk, arst_n, rsp_valid && int'(rsp.cursor_pos) >= tcw_pkg::CELL_COUNT, "cursor beyond screen")
	`TCW_ASSERT(a_scroll_row, clk, arst_n, rsp_valid && rsp.scrolled |-> rsp.cursor_pos >= tcw_pkg::LAST_LINE, "scroll left cursor above bottom row")

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

@@ sim/tb_text_console_writer.sv @@
// ----------------------------------------------------------------------------
// tb_text_console_writer
// Self-checking bench for the text console writer. A shadow of the screen
// store, the cursor and the default colour predicts every result word. The
// bench runs a short directed sequence, then four random phases, each setting
// the default colour and running under a different mix of sender gaps and
// result stalls.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
	timeunit 1ns;
	timeprecision 1ps;
	import tcw_pkg::*;

	localparam int IDLE_LIMIT      = 20000;
	localparam int WORDS_PER_PHASE = 500;
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;
	localparam logic [CFG_ADDR_W-1:0] ADDR_DEFAULT_COLOR = {REG_DEFAULT_COLOR, 2'b00};

	class console_shadow;
		logic [15:0] cells [CELL_COUNT];
		int unsigned cur;
		logic [7:0]  dflt;
		out_word_t   awaited [$];
		int          errors;
		int          words;
		int          scrolls;
		int          reads;

		function new();
			for (int i = 0; i < CELL_COUNT; i++) cells[i] = {RESET_ATTR, BLANK_CHAR};
			cur = 0;
			dflt = RESET_ATTR;
			errors = 0;
			words = 0;
			scrolls = 0;
			reads = 0;
		endfunction

		function void scroll_screen();
			for (int i = 0; i < CELL_COUNT - COLS; i++) cells[i] = cells[i + COLS];
			for (int i = CELL_COUNT - COLS; i < CELL_COUNT; i++) cells[i] = {dflt, BLANK_CHAR};
		endfunction

		function bit put_cell(logic [7:0] ch, logic [7:0] attr);
			if (cur >= CELL_COUNT) cur = 0;
			cells[cur] = {attr, ch};
			cur++;
			if (cur >= CELL_COUNT) begin
				scroll_screen();
				cur = CELL_COUNT - COLS;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void apply_word(in_word_t w);
			out_word_t   r;
			bit          sc;
			int unsigned line;
			int unsigned spaces;
			r = '0;
			sc = 1'b0;
			words++;
			if (cur >= CELL_COUNT) cur = 0;
			case (w.op)
				OP_TEXT: begin
					if (w.char_code == CODE_NEWLINE) begin
						line = cur / COLS;
						if (line == ROWS - 1) begin
							scroll_screen();
							sc = 1'b1;
						end else begin
							line++;
						end
						cur = line * COLS;
					end else if (w.char_code == CODE_TAB) begin
						spaces = TAB_WIDTH - cur % TAB_WIDTH;
						repeat (spaces) if (put_cell(BLANK_CHAR, dflt)) sc = 1'b1;
					end else begin
						sc = put_cell(w.char_code, dflt);
					end
				end
				OP_RAW: sc = put_cell(w.char_code, w.color);
				OP_AT: begin
					if (w.row < ROWS && w.col < COLS)
						cells[w.row * COLS + w.col] = {w.color, w.char_code};
				end
				OP_CURSOR: begin
					if (w.cursor_target < CELL_COUNT) cur = w.cursor_target;
				end
				OP_READ: begin
					if (w.row < ROWS && w.col < COLS) begin
						r.read_char  = cells[w.row * COLS + w.col][7:0];
						r.read_color = cells[w.row * COLS + w.col][15:8];
						reads++;
					end
				end
				default: ;
			endcase
			r.cursor_pos = 11'(cur);
			r.scrolled = sc;
			if (sc) scrolls++;
			awaited.push_back(r);
		endfunction

		function void compare(string field, logic [10:0] want, logic [10:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
			end
		endfunction

		function void check_rsp(out_word_t r);
			out_word_t e;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual cursor_pos 0x%0h",
					$time, r.cursor_pos);
				return;
			end
			e = awaited.pop_front();
			compare("cursor_pos", e.cursor_pos, r.cursor_pos);
			compare("read_char", 11'(e.read_char), 11'(r.read_char));
			compare("read_color", 11'(e.read_color), 11'(r.read_color));
			compare("scrolled", 11'(e.scrolled), 11'(r.scrolled));
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               req_valid = 1'b0;
	logic               req_stall;
	in_word_t           req = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	out_word_t          rsp;

	console_shadow shadow = new();
	int send_idle_pct = 0;
	int stall_pct = 0;
	int quiet = 0;

	text_console_writer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		rsp_stall = ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
			else quiet++;
			if (rsp_valid && !rsp_stall) shadow.check_rsp(rsp);
			if (quiet >= IDLE_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	function automatic in_word_t make_word(logic [2:0] op, logic [7:0] ch, logic [7:0] color,
		logic [4:0] row, logic [6:0] col, logic [10:0] target);
		in_word_t w;
		w.op = op;
		w.char_code = ch;
		w.color = color;
		w.row = row;
		w.col = col;
		w.cursor_target = target;
		return w;
	endfunction

	function automatic in_word_t rand_word();
		in_word_t    w;
		logic [63:0] raw;
		int          pick;
		raw = {$urandom, $urandom};
		w = raw[$bits(in_word_t)-1:0];
		pick = $urandom_range(99);
		if (pick < 30) begin
			w.op = OP_TEXT;
			case ($urandom_range(7))
				0: w.char_code = CODE_NEWLINE;
				1: w.char_code = CODE_TAB;
				default: ;
			endcase
		end else if (pick < 45) begin
			w.op = OP_RAW;
		end else if (pick < 69) begin
			w.op = (pick < 57) ? OP_AT : OP_CURSOR;
			if ($urandom_range(99) < 85) begin
				w.row = 5'($urandom_range(ROWS - 1));
				w.col = 7'($urandom_range(COLS - 1));
			end
			pick = $urandom_range(99);
			if (pick < 60) w.cursor_target = 11'($urandom_range(CELL_COUNT - 1));
			else if (pick < 85) w.cursor_target = 11'($urandom_range(CELL_COUNT - 1, CELL_COUNT - 100));
			else w.cursor_target = 11'($urandom_range(2047, CELL_COUNT));
		end else if (pick < 95) begin
			w.op = OP_READ;
			if ($urandom_range(99) < 85) begin
				w.row = 5'($urandom_range(ROWS - 1));
				w.col = 7'($urandom_range(COLS - 1));
			end
		end else begin
			w.op = 3'($urandom_range(OP_SPARE_HI, OP_SPARE_LO));
		end
		return w;
	endfunction

	task automatic send_word(input in_word_t w);
		logic [63:0] noise;
		while ($urandom_range(99) < send_idle_pct) begin
			noise = {$urandom, $urandom};
			req_valid = 1'b0;
			req = noise[$bits(in_word_t)-1:0];
			@(negedge clk);
		end
		req_valid = 1'b1;
		req = w;
		do @(posedge clk); while (req_stall);
		shadow.apply_word(w);
		@(negedge clk);
	endtask

	task automatic set_default_color(input logic [7:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = ADDR_DEFAULT_COLOR;
		pwdata = {24'd0, value};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		shadow.dflt = value;
		@(negedge clk);
		penable = 1'b0;
		pwrite = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		if (prdata !== {24'd0, value}) begin
			shadow.errors++;
			$display("%0t: default_color readback mismatch, expected 0x%0h, actual 0x%0h",
				$time, {24'd0, value}, prdata);
		end
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	// drop valid, wait for every outstanding result, then let the block settle
	task automatic drain();
		req_valid = 1'b0;
		while (shadow.awaited.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_word(make_word(OP_READ,    8'h00, 8'h00, 5'd0,  7'd0,   11'd0));
		send_word(make_word(OP_TEXT,    8'h41, 8'h00, 5'd0,  7'd0,   11'd0));
		send_word(make_word(OP_TEXT,    8'h00, 8'hFF, 5'd31, 7'd127, 11'd2047));
		send_word(make_word(OP_TEXT,    CODE_TAB, 8'h00, 5'd0, 7'd0, 11'd0));
		send_word(make_word(OP_TEXT,    CODE_NEWLINE, 8'h00, 5'd0, 7'd0, 11'd0));
		send_word(make_word(OP_RAW,     8'hFF, 8'hFF, 5'd0,  7'd0,   11'd0));
		send_word(make_word(OP_AT,      8'hFF, 8'h00, 5'd24, 7'd79,  11'd0));
		send_word(make_word(OP_AT,      8'h11, 8'h22, 5'd25, 7'd0,   11'd0));
		send_word(make_word(OP_AT,      8'h33, 8'h44, 5'd0,  7'd80,  11'd0));
		send_word(make_word(OP_AT,      8'hFF, 8'hFF, 5'd31, 7'd127, 11'd0));
		send_word(make_word(OP_READ,    8'h00, 8'h00, 5'd24, 7'd79,  11'd0));
		send_word(make_word(OP_READ,    8'hFF, 8'hFF, 5'd31, 7'd127, 11'd2047));
		send_word(make_word(OP_READ,    8'h00, 8'h00, 5'd0,  7'd80,  11'd0));
		send_word(make_word(OP_READ,    8'h00, 8'h00, 5'd0,  7'd1,   11'd0));
		send_word(make_word(OP_CURSOR,  8'h00, 8'h00, 5'd0,  7'd0,   11'd2047));
		send_word(make_word(OP_CURSOR,  8'h00, 8'h00, 5'd0,  7'd0,   11'd2000));
		send_word(make_word(OP_CURSOR,  8'h00, 8'h00, 5'd0,  7'd0,   11'd1999));
		send_word(make_word(OP_RAW,     8'h55, 8'hAA, 5'd0,  7'd0,   11'd0));
		send_word(make_word(OP_TEXT,    CODE_NEWLINE, 8'h00, 5'd0, 7'd0, 11'd0));
		send_word(make_word(OP_CURSOR,  8'h00, 8'h00, 5'd0,  7'd0,   11'd1998));
		send_word(make_word(OP_TEXT,    CODE_TAB, 8'h00, 5'd0, 7'd0, 11'd0));
		send_word(make_word(OP_READ,    8'h00, 8'h00, 5'd23, 7'd79,  11'd0));
		send_word(make_word(OP_SPARE_LO, 8'hFF, 8'hFF, 5'd31, 7'd127, 11'd2047));
		send_word(make_word(OP_SPARE_HI, 8'hFF, 8'hFF, 5'd31, 7'd127, 11'd2047));
		send_word(make_word(OP_CURSOR,  8'h00, 8'h00, 5'd0,  7'd0,   11'd0));

		for (int ph = 0; ph < 4; ph++) begin
			drain();
			case (ph)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
					set_default_color(8'h00);
				end
				1: begin
					send_idle_pct = 61;
					stall_pct = 0;
					set_default_color(8'hFF);
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 61;
					set_default_color(8'($urandom_range(254, 1)));
				end
				default: begin
					send_idle_pct = 21;
					stall_pct = 21;
					set_default_color(RESET_ATTR);
				end
			endcase
			repeat (WORDS_PER_PHASE) send_word(rand_word());
		end

		drain();
		repeat (100) @(posedge clk);
		if (shadow.awaited.size() != 0)
			$display("%0t: %0d expected results never arrived", $time, shadow.awaited.size());
		$display("Checked %0d console words: directed edges, then four random phases",
			shadow.words);
		$display("under colour extremes and mixed gaps/stalls; %0d scrolls, %0d cell reads.",
			shadow.scrolls, shadow.reads);
		if (shadow.errors == 0 && shadow.awaited.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end
endmodule
